@@ rtl/keypad_decimal_calculator_assert.svh @@
// assertion macros for the checker file
`ifndef KEYPAD_DECIMAL_CALCULATOR_ASSERT_SVH
`define KEYPAD_DECIMAL_CALCULATOR_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define KDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define KDC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/kdc_pkg.sv @@
package kdc_pkg;

  // key codes
  localparam logic [7:0] KEY_DIGIT_LO = 8'd48;
  localparam logic [7:0] KEY_DIGIT_HI = 8'd57;
  localparam logic [7:0] KEY_OP_A     = 8'h41;
  localparam logic [7:0] KEY_OP_D     = 8'h44;

  // datapath widths
  localparam int unsigned OPERAND_W  = 30;
  localparam int unsigned RESULT_W   = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STEP_CNT_W = $clog2(OPERAND_W + 1);
  localparam logic [STEP_CNT_W-1:0] MUL_DIV_STEPS = STEP_CNT_W'(OPERAND_W);
  localparam logic [STEP_CNT_W-1:0] ADD_SUB_STEPS = STEP_CNT_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } kdc_op_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } kdc_phase_e;

  typedef enum logic [1:0] {
    ALU_IDLE = 2'd0,
    ALU_RUN  = 2'd1,
    ALU_DONE = 2'd2
  } kdc_alu_state_e;

  // operands handed from the key sequencer to the arithmetic unit
  typedef struct packed {
    kdc_op_e              op;
    logic [OPERAND_W-1:0] a;
    logic [OPERAND_W-1:0] b;
  } kdc_req_t;

  // finished result from the arithmetic unit
  typedef struct packed {
    logic [RESULT_W-1:0] value;
    kdc_op_e             op;
    logic                dz;
  } kdc_res_t;

endpackage

@@ rtl/kdc_seq.sv @@
module kdc_seq
  import kdc_pkg::*;
#(
  parameter int unsigned DIGITS_PER_OPERAND = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       key_valid_i,
  input  logic [7:0] key_i,
  output logic       start_o,
  output kdc_req_t   req_o
);

  localparam logic [3:0] LAST_CNT = 4'(DIGITS_PER_OPERAND - 1);

  kdc_phase_e           phase_q, phase_d;
  kdc_op_e              op_q, op_d;
  logic [OPERAND_W-1:0] first_q, first_d;
  logic [OPERAND_W-1:0] acc_q, acc_d;
  logic [3:0]           cnt_q, cnt_d;

  logic                 is_digit, is_op, last_digit;
  logic [3:0]           digit;
  logic [OPERAND_W+3:0] acc_x10;

  // key decode
  assign is_digit   = key_i inside {[KEY_DIGIT_LO:KEY_DIGIT_HI]};
  assign is_op      = key_i inside {[KEY_OP_A:KEY_OP_D]};
  assign digit      = 4'(key_i - KEY_DIGIT_LO);
  assign last_digit = (cnt_q == LAST_CNT);
  assign acc_x10    = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {30'd0, digit};

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_FIRST: begin
        if (key_valid_i && is_digit && last_digit) phase_d = PH_SECOND;
      end
      PH_SECOND: begin
        if (key_valid_i && is_digit && last_digit) phase_d = PH_IDLE;
      end
      default: begin
        if (key_valid_i && is_op) phase_d = PH_FIRST;
        else phase_d = PH_IDLE;
      end
    endcase
  end

  // operand gathering and start request
  always_comb begin
    op_d    = op_q;
    first_d = first_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    start_o = 1'b0;
    req_o   = '{op: op_q, a: first_q, b: acc_x10[OPERAND_W-1:0]};
    case (phase_q)
      PH_FIRST, PH_SECOND: begin
        if (key_valid_i && is_digit) begin
          if (last_digit) begin
            cnt_d = '0;
            acc_d = '0;
            if (phase_q == PH_FIRST) first_d = acc_x10[OPERAND_W-1:0];
            else begin
              first_d = '0;
              start_o = 1'b1;
            end
          end else begin
            cnt_d = cnt_q + 4'd1;
            acc_d = acc_x10[OPERAND_W-1:0];
          end
        end
      end
      default: begin
        if (key_valid_i && is_op) begin
          op_d    = kdc_op_e'(2'(key_i - KEY_OP_A));
          first_d = '0;
          acc_d   = '0;
          cnt_d   = '0;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= OP_ADD;
      first_q <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      first_q <= first_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ rtl/kdc_alu.sv @@
module kdc_alu
  import kdc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  kdc_req_t req_i,
  input  logic     res_ready_i,
  output logic     busy_o,
  output logic     res_valid_o,
  output kdc_res_t res_o
);

  kdc_alu_state_e        state_q, state_d;
  kdc_op_e               op_q;
  logic [RESULT_W-1:0]   acc_q;   // sum, product or remainder
  logic [RESULT_W-1:0]   sh_q;    // shifted multiplicand or dividend / quotient
  logic [OPERAND_W-1:0]  b_q;     // multiplier bits or divisor
  logic [STEP_CNT_W-1:0] cnt_q;
  logic                  dz_q;

  logic                  zero_div;
  logic [RESULT_W-1:0]   add_x, add_y, rem_shift;
  logic                  add_sub;
  logic [RESULT_W:0]     add_sum;

  assign zero_div  = (req_i.op == OP_DIV) && (req_i.b == '0);
  assign rem_shift = {acc_q[RESULT_W-2:0], sh_q[OPERAND_W-1]};

  // shared adder operand select
  always_comb begin
    add_x   = sh_q;
    add_y   = {{(RESULT_W-OPERAND_W){1'b0}}, b_q};
    add_sub = 1'b0;
    case (op_q)
      OP_ADD: begin
        add_sub = 1'b0;
      end
      OP_SUB: begin
        add_sub = 1'b1;
      end
      OP_MUL: begin
        add_x = acc_q;
        add_y = sh_q;
      end
      default: begin
        add_x   = rem_shift;
        add_sub = 1'b1;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {RESULT_W{add_sub}}}
                 + {{RESULT_W{1'b0}}, add_sub};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ALU_IDLE: begin
        if (start_i) state_d = zero_div ? ALU_DONE : ALU_RUN;
      end
      ALU_RUN: begin
        if (cnt_q == STEP_CNT_W'(1)) state_d = ALU_DONE;
      end
      ALU_DONE: begin
        if (res_ready_i) state_d = ALU_IDLE;
      end
      default: state_d = ALU_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o      = (state_q != ALU_IDLE);
    res_valid_o = (state_q == ALU_DONE);
    res_o.op    = op_q;
    res_o.dz    = dz_q;
    if (op_q == OP_DIV) begin
      res_o.value = dz_q ? '0 : {{(RESULT_W-OPERAND_W){1'b0}}, sh_q[OPERAND_W-1:0]};
    end else begin
      res_o.value = acc_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ALU_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ALU_IDLE && start_i) begin
        cnt_q <= (req_i.op == OP_ADD || req_i.op == OP_SUB) ? ADD_SUB_STEPS : MUL_DIV_STEPS;
      end else if (state_q == ALU_RUN) begin
        cnt_q <= cnt_q - STEP_CNT_W'(1);
      end
    end
  end

  // datapath: one adder step per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ALU_IDLE && start_i) begin
      op_q  <= req_i.op;
      dz_q  <= zero_div;
      acc_q <= '0;
      sh_q  <= {{(RESULT_W-OPERAND_W){1'b0}}, req_i.a};
      b_q   <= req_i.b;
    end else if (state_q == ALU_RUN) begin
      case (op_q)
        OP_ADD, OP_SUB: begin
          acc_q <= add_sum[RESULT_W-1:0];
        end
        OP_MUL: begin
          if (b_q[0]) acc_q <= add_sum[RESULT_W-1:0];
          sh_q <= {sh_q[RESULT_W-2:0], 1'b0};
          b_q  <= {1'b0, b_q[OPERAND_W-1:1]};
        end
        default: begin
          acc_q <= add_sum[RESULT_W] ? add_sum[RESULT_W-1:0] : rem_shift;
          sh_q  <= {sh_q[RESULT_W-2:0], add_sum[RESULT_W]};
        end
      endcase
    end
  end

endmodule

@@ rtl/keypad_decimal_calculator.sv @@
// channel  dir  signals                      payload
// s_axis   in   tvalid/tready/tdata[7:0]     key_code
// m_axis   out  tvalid/tready/tdata[31:0]    result_value
//               tuser[2:0]                   operation, divide_by_zero
//
// the completing digit starts the shared adder: add and subtract take 1 step,
// multiply (shift-add) and divide (restoring) take 30 steps, one per cycle,
// plus the output register; divide by zero takes none
// s_axis_tready_o is low while the arithmetic unit holds an operation
// reset (rst_ni low, asynchronous) returns to idle and empties the output
// a stalled result stays in the output register; keys are taken until the next operation starts
module keypad_decimal_calculator
  import kdc_pkg::*;
#(
  parameter int unsigned DIGITS_PER_OPERAND = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] key_code
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] result_value
  output logic [2:0]  m_axis_tuser_o    // [1:0] operation, [2] divide_by_zero
);

  logic     key_valid, start, alu_busy, res_valid, res_load;
  kdc_req_t req;
  kdc_res_t res;
  logic     out_valid_q, out_valid_d;
  kdc_res_t out_q;

  assign s_axis_tready_o = !alu_busy;
  assign key_valid       = s_axis_tvalid_i && s_axis_tready_o;

  kdc_seq #(
    .DIGITS_PER_OPERAND(DIGITS_PER_OPERAND)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_valid_i(key_valid),
    .key_i      (s_axis_tdata_i),
    .start_o    (start),
    .req_o      (req)
  );

  kdc_alu u_alu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req),
    .res_ready_i(res_load),
    .busy_o     (alu_busy),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // output register
  assign res_load = res_valid && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (res_load) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.value;
  assign m_axis_tuser_o  = {out_q.dz, out_q.op};

endmodule

@@ rtl/kdc_checker.sv @@
`include "keypad_decimal_calculator_assert.svh"

module kdc_checker
  import kdc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // output empty while in reset
  `KDC_ASSERT_RST(a_reset_empty, !rst_ni |-> !m_axis_tvalid_o, "result valid in reset")

  // a stalled result holds
  `KDC_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

  // divide by zero only on a divide, with a zero result
  `KDC_ASSERT(a_dz_value, m_axis_tvalid_o && m_axis_tuser_o[2] |-> m_axis_tuser_o[1:0] == OP_DIV && m_axis_tdata_o == 32'd0, "bad divide by zero result")

  // a new result comes only out of a busy arithmetic unit
  `KDC_ASSERT(a_rise_busy, $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o), "result without busy unit")

endmodule

bind keypad_decimal_calculator kdc_checker u_checker (.*);

@@ verif/tb_keypad_decimal_calculator.sv @@
`timescale 1ns / 1ps

module tb_keypad_decimal_calculator;
  import kdc_pkg::*;

  localparam int unsigned DIGITS      = 3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 50;
  localparam int unsigned PHASE_KEYS  = 280;

  logic        clk_i   = 1'b0;
  logic        rst_ni;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data  = 8'h00;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  logic [2:0]  m_user;

  // keys waiting to be driven and results waiting to be seen
  logic [7:0]  key_queue[$];
  kdc_res_t    pending_results[$];
  kdc_res_t    want_res;
  int unsigned keys_queued    = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // calculator state as predicted from the accepted keys
  kdc_phase_e  calc_phase = PH_IDLE;
  kdc_op_e     calc_op    = OP_ADD;
  logic [29:0] calc_first = '0;
  logic [29:0] calc_acc   = '0;
  logic [3:0]  calc_count = '0;

  keypad_decimal_calculator #(
    .DIGITS_PER_OPERAND(DIGITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // advance the predicted calculator by one accepted key
  task automatic calc_apply_key(input logic [7:0] key);
    kdc_res_t    res;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] next_acc;
    if (calc_phase != PH_FIRST && calc_phase != PH_SECOND) begin
      if (key >= KEY_OP_A && key <= KEY_OP_D) begin
        calc_op    = kdc_op_e'(2'(key - KEY_OP_A));
        calc_phase = PH_FIRST;
        calc_acc   = '0;
        calc_first = '0;
        calc_count = '0;
      end else begin
        calc_phase = PH_IDLE;
      end
      return;
    end
    if (key < KEY_DIGIT_LO || key > KEY_DIGIT_HI) return;
    next_acc   = {2'b00, calc_acc} * 32'd10 + 32'(key - KEY_DIGIT_LO);
    calc_acc   = next_acc[29:0];
    calc_count = calc_count + 4'd1;
    if (calc_count < 4'(DIGITS)) return;
    calc_count = '0;
    if (calc_phase == PH_FIRST) begin
      calc_first = calc_acc;
      calc_acc   = '0;
      calc_phase = PH_SECOND;
      return;
    end
    lhs       = {2'b00, calc_first};
    rhs       = {2'b00, calc_acc};
    res.op    = calc_op;
    res.dz    = 1'b0;
    case (calc_op)
      OP_ADD: res.value = lhs + rhs;
      OP_SUB: res.value = lhs - rhs;
      OP_MUL: res.value = lhs * rhs;
      default: begin
        if (rhs == 32'd0) begin
          res.value = '0;
          res.dz    = 1'b1;
        end else begin
          res.value = lhs / rhs;
        end
      end
    endcase
    pending_results.push_back(res);
    calc_phase = PH_IDLE;
    calc_acc   = '0;
    calc_first = '0;
  endtask

  task automatic push_key(input logic [7:0] key);
    key_queue.push_back(key);
    keys_queued++;
  endtask

  task automatic push_text(input string keys);
    for (int i = 0; i < keys.len(); i++) push_key(keys[i]);
  endtask

  // any key that is not a digit
  task automatic push_non_digit();
    int unsigned k;
    k = $urandom_range(0, 245);
    if (k >= 48) k = k + 10;
    push_key(8'(k));
  endtask

  // key driver, runs the predictor on every accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= 8'h00;
    end else begin
      if (s_valid && s_ready) calc_apply_key(s_data);
      if (!s_valid || s_ready) begin
        if (key_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_valid <= 1'b1;
          s_data  <= key_queue.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual value %0d op %0d dz %0b",
                 $time, $signed(m_data), m_user[1:0], m_user[2]);
        mismatch_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (m_data !== want_res.value) begin
          $display("%0t: result_value mismatch, expected %0d actual %0d",
                   $time, $signed(want_res.value), $signed(m_data));
          mismatch_count++;
        end
        if (m_user[1:0] !== want_res.op) begin
          $display("%0t: operation mismatch, expected %0d actual %0d",
                   $time, want_res.op, m_user[1:0]);
          mismatch_count++;
        end
        if (m_user[2] !== want_res.dz) begin
          $display("%0t: divide_by_zero mismatch, expected %0b actual %0b",
                   $time, want_res.dz, m_user[2]);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles + 1 >= STALL_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned target;
    int unsigned cut;
    int unsigned mode;
    // falling edge at time zero so the asynchronous reset takes effect at once
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct  = 28;
          recv_stall_pct = 28;
        end
      endcase

      if (ph == 0) begin
        // keys ignored while idle, including a digit
        push_key(8'h00);
        push_key(8'hFF);
        push_text("7");
        // divide by zero
        push_text("D999000");
        // operation key while gathering, negative difference
        push_text("B0A00999");
        // largest product
        push_text("C999999");
        // largest sum
        push_text("A999999");
      end

      target = keys_queued + PHASE_KEYS;
      while (keys_queued < target) begin
        if ($urandom_range(0, 9) == 0) push_non_digit();
        push_key(KEY_OP_A + 8'($urandom_range(0, 3)));
        // a few sequences break off early
        cut  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 5) : 2 * DIGITS;
        mode = 0;
        for (int i = 0; i < cut; i++) begin
          if (i % DIGITS == 0) mode = $urandom_range(0, 7);
          if ($urandom_range(0, 11) == 0) push_non_digit();
          case (mode)
            0:       push_key(KEY_DIGIT_LO);
            1:       push_key(KEY_DIGIT_HI);
            default: push_key(8'($urandom_range(KEY_DIGIT_LO, KEY_DIGIT_HI)));
          endcase
        end
      end

      while (key_queue.size() != 0 || s_valid) @(posedge clk_i);
    end

    // drain outstanding results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ keypad_decimal_calculator.f @@
+incdir+rtl
rtl/kdc_pkg.sv
rtl/kdc_seq.sv
rtl/kdc_alu.sv
rtl/keypad_decimal_calculator.sv
rtl/kdc_checker.sv
verif/tb_keypad_decimal_calculator.sv
